[rtl/tcal_pkg.sv]
// Package for the TCP challenge-ACK limiter: event and reply codes, register map,
// reset values and the connection state / reply tables.
// No dependencies.
package tcal_pkg;

    localparam int DEF_TIME_WIDTH = 32;
    localparam int DEF_STAT_WIDTH = 32;

    localparam int NUM_STATES = 10;
    localparam int NUM_EVENTS = 6;

    localparam logic [2:0] EV_SYN   = 3'd0;
    localparam logic [2:0] EV_ACK   = 3'd1;
    localparam logic [2:0] EV_FIN   = 3'd2;
    localparam logic [2:0] EV_RST   = 3'd3;
    localparam logic [2:0] EV_DATA  = 3'd4;
    localparam logic [2:0] EV_CLOSE = 3'd5;

    localparam logic [2:0] RP_SILENT = 3'd0;
    localparam logic [2:0] RP_SYNACK = 3'd1;
    localparam logic [2:0] RP_ACK    = 3'd2;
    localparam logic [2:0] RP_RST    = 3'd3;
    localparam logic [2:0] RP_FINACK = 3'd4;

    localparam logic CMD_RESET = 1'b0;
    localparam logic CMD_EVENT = 1'b1;

    localparam logic [3:0] ST_LISTEN     = 4'd0;
    localparam logic [3:0] ST_CHAL_FIRST = 4'd2;
    localparam logic [3:0] ST_CHAL_LAST  = 4'd8;
    localparam logic [3:0] ST_LAST       = 4'd9;

    localparam int PADDR_WIDTH = 3;
    localparam logic REG_ACK_LIMIT  = 1'b0;
    localparam logic REG_WINDOW_LEN = 1'b1;

    localparam int LIMIT_WIDTH = 21;
    localparam logic [LIMIT_WIDTH-1:0] ACK_LIMIT_RST  = 21'd10;
    localparam logic [31:0]            WINDOW_LEN_RST = 32'd10000;

    typedef logic [3:0] t_state;
    typedef logic [2:0] t_code;

    localparam t_state NEXT_TAB [NUM_STATES][NUM_EVENTS] = '{
        '{4'd1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd9},
        '{4'd1, 4'd2, 4'd3, 4'd0, 4'd1, 4'd5},
        '{4'd2, 4'd2, 4'd3, 4'd9, 4'd2, 4'd5},
        '{4'd3, 4'd3, 4'd3, 4'd9, 4'd3, 4'd4},
        '{4'd4, 4'd9, 4'd4, 4'd9, 4'd4, 4'd4},
        '{4'd5, 4'd6, 4'd7, 4'd9, 4'd5, 4'd5},
        '{4'd6, 4'd6, 4'd8, 4'd9, 4'd6, 4'd6},
        '{4'd7, 4'd8, 4'd7, 4'd9, 4'd7, 4'd7},
        '{4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8},
        '{4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9}
    };

    localparam t_code REPLY_TAB [NUM_STATES][NUM_EVENTS] = '{
        '{RP_SYNACK, RP_RST,    RP_SILENT, RP_SILENT, RP_RST,    RP_SILENT},
        '{RP_SILENT, RP_SILENT, RP_ACK,    RP_SILENT, RP_SILENT, RP_FINACK},
        '{RP_ACK,    RP_SILENT, RP_ACK,    RP_SILENT, RP_ACK,    RP_FINACK},
        '{RP_ACK,    RP_SILENT, RP_ACK,    RP_SILENT, RP_ACK,    RP_FINACK},
        '{RP_ACK,    RP_SILENT, RP_ACK,    RP_SILENT, RP_SILENT, RP_SILENT},
        '{RP_ACK,    RP_SILENT, RP_ACK,    RP_SILENT, RP_ACK,    RP_SILENT},
        '{RP_ACK,    RP_SILENT, RP_ACK,    RP_SILENT, RP_ACK,    RP_SILENT},
        '{RP_ACK,    RP_SILENT, RP_ACK,    RP_SILENT, RP_SILENT, RP_SILENT},
        '{RP_ACK,    RP_SILENT, RP_ACK,    RP_SILENT, RP_SILENT, RP_SILENT},
        '{RP_RST,    RP_RST,    RP_RST,    RP_SILENT, RP_RST,    RP_SILENT}
    };

endpackage

[rtl/tcal_if.sv]
// Request and response channels of the TCP challenge-ACK limiter.
// Valid/ready handshake with payload; no dependencies.
interface tcal_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [2:0]  event_req;
    logic [31:0] time_now;

    modport source (output valid, cmd, event_req, time_now, input ready);
    modport sink (input valid, cmd, event_req, time_now, output ready);
endinterface

interface tcal_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  reply;
    logic [3:0]  conn_state;
    logic        was_suppressed;
    logic [31:0] granted_total;
    logic [31:0] suppressed_total;

    modport source (output valid, reply, conn_state, was_suppressed, granted_total,
                    suppressed_total, input ready);
    modport sink (input valid, reply, conn_state, was_suppressed, granted_total,
                  suppressed_total, output ready);
endinterface

[rtl/tcp_endpoint_challenge_ack_limiter.sv]
// Top level of the TCP challenge-ACK limiter: connection state, window and totals.
// Depends on tcal_pkg and the channel interfaces in tcal_if.sv.
//
// One request per clock is taken; its response goes into the output or skid
// register. The state table lookup, the window compare and the counter updates
// all resolve in the acceptance cycle against the connection registers, so a
// request can follow in the very next cycle. Responses leave through a two-entry
// buffer (output register plus skid register): a request is still taken while one
// response waits, and ready drops only while both are held. Registers ack_limit
// (0x0) and window_len (0x4) are written over the APB port only while no request
// is in flight, which the block does not enforce; reads return the current values.
module tcp_endpoint_challenge_ack_limiter #(
    parameter int TIME_WIDTH = tcal_pkg::DEF_TIME_WIDTH,
    parameter int STAT_WIDTH = tcal_pkg::DEF_STAT_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    tcal_req_if.sink                          i_req,
    tcal_rsp_if.source                        o_rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tcal_pkg::PADDR_WIDTH-1:0]  paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import tcal_pkg::*;

    localparam int CMP_WIDTH = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

    typedef struct packed {
        logic [2:0]  reply;
        logic [3:0]  conn_state;
        logic        was_suppressed;
        logic [31:0] granted_total;
        logic [31:0] suppressed_total;
    } t_rsp;

    logic [LIMIT_WIDTH-1:0] r_ack_limit;
    logic [31:0]            r_window_len;

    t_state                 r_state;
    logic [TIME_WIDTH-1:0]  r_window_start;
    logic                   r_window_open;
    logic [LIMIT_WIDTH-1:0] r_count;
    logic [STAT_WIDTH-1:0]  r_granted;
    logic [STAT_WIDTH-1:0]  r_suppressed;

    t_rsp r_out;
    t_rsp r_skid;
    logic r_out_valid;
    logic r_skid_valid;

    t_state                 n_state;
    logic [TIME_WIDTH-1:0]  n_window_start;
    logic                   n_window_open;
    logic [LIMIT_WIDTH-1:0] n_count;
    logic [STAT_WIDTH-1:0]  n_granted;
    logic [STAT_WIDTH-1:0]  n_suppressed;
    t_rsp                   n_rsp;

    logic                  acc;
    logic                  pop;
    logic                  cfg_wr;
    t_state                cur_s;
    logic [TIME_WIDTH-1:0] now_t;
    logic [TIME_WIDTH-1:0] elapsed;
    logic                  is_chal;
    logic                  open_new;
    logic                  grant;
    logic                  supp;
    t_code                 tab_reply;
    t_state                tab_next;

    assign acc    = i_req.valid && i_req.ready;
    assign pop    = r_out_valid && o_rsp.ready;
    assign cfg_wr = psel && penable && pwrite && pready;

    assign i_req.ready = !r_skid_valid;
    assign pready      = 1'b1;

    always_comb begin
        case (paddr[2])
            REG_ACK_LIMIT:  prdata = 32'(r_ack_limit);
            REG_WINDOW_LEN: prdata = r_window_len;
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_limit  <= ACK_LIMIT_RST;
            r_window_len <= WINDOW_LEN_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_ACK_LIMIT:  r_ack_limit  <= pwdata[LIMIT_WIDTH-1:0];
                REG_WINDOW_LEN: r_window_len <= pwdata;
                default:        r_ack_limit  <= r_ack_limit;
            endcase
        end
    end

    assign cur_s     = (r_state <= ST_LAST) ? r_state : ST_LISTEN;
    assign now_t     = TIME_WIDTH'(i_req.time_now);
    assign elapsed   = now_t - r_window_start;
    assign tab_next  = (i_req.event_req < 3'(NUM_EVENTS))
                       ? NEXT_TAB[cur_s][i_req.event_req] : cur_s;
    assign tab_reply = (i_req.event_req < 3'(NUM_EVENTS))
                       ? REPLY_TAB[cur_s][i_req.event_req] : RP_SILENT;
    assign is_chal   = (i_req.cmd == CMD_EVENT) && (i_req.event_req == EV_SYN)
                       && (cur_s >= ST_CHAL_FIRST) && (cur_s <= ST_CHAL_LAST);
    assign open_new  = !r_window_open || (CMP_WIDTH'(elapsed) >= CMP_WIDTH'(r_window_len));
    assign grant     = is_chal && (open_new || (r_count < r_ack_limit));
    assign supp      = is_chal && !grant;

    always_comb begin
        n_state        = r_state;
        n_window_start = r_window_start;
        n_window_open  = r_window_open;
        n_count        = r_count;
        n_granted      = r_granted;
        n_suppressed   = r_suppressed;
        n_rsp.reply    = RP_SILENT;
        if (i_req.cmd == CMD_RESET) begin
            n_state        = ST_LISTEN;
            n_window_start = '0;
            n_window_open  = 1'b0;
            n_count        = '0;
        end else begin
            n_state     = tab_next;
            n_rsp.reply = supp ? RP_SILENT : tab_reply;
            if (grant) begin
                if (open_new) begin
                    n_window_start = now_t;
                    n_window_open  = 1'b1;
                    n_count        = LIMIT_WIDTH'(1);
                end else begin
                    n_count = r_count + LIMIT_WIDTH'(1);
                end
                if (r_granted != '1) begin
                    n_granted = r_granted + STAT_WIDTH'(1);
                end
            end
            if (supp && (r_suppressed != '1)) begin
                n_suppressed = r_suppressed + STAT_WIDTH'(1);
            end
        end
        n_rsp.conn_state       = n_state;
        n_rsp.was_suppressed   = supp;
        n_rsp.granted_total    = 32'(n_granted);
        n_rsp.suppressed_total = 32'(n_suppressed);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_LISTEN;
            r_window_start <= '0;
            r_window_open  <= 1'b0;
            r_count        <= '0;
            r_granted      <= '0;
            r_suppressed   <= '0;
        end else if (acc) begin
            r_state        <= n_state;
            r_window_start <= n_window_start;
            r_window_open  <= n_window_open;
            r_count        <= n_count;
            r_granted      <= n_granted;
            r_suppressed   <= n_suppressed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid       <= n_rsp;
                r_skid_valid <= acc;
            end else begin
                r_out        <= n_rsp;
                r_out_valid  <= acc;
            end
        end else if (acc) begin
            r_skid       <= n_rsp;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.reply            = r_out.reply;
    assign o_rsp.conn_state       = r_out.conn_state;
    assign o_rsp.was_suppressed   = r_out.was_suppressed;
    assign o_rsp.granted_total    = r_out.granted_total;
    assign o_rsp.suppressed_total = r_out.suppressed_total;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_supp_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.was_suppressed) |-> (o_rsp.reply == RP_SILENT))
        else $error("suppressed challenge carries a reply");

    a_state_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state <= ST_LAST)
        else $error("connection state out of range");

    a_cmd_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_req.cmd == CMD_RESET)) |=> (!r_window_open && (r_state == ST_LISTEN)))
        else $error("command reset did not clear the connection");

    a_window_on_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && grant) |=> (r_window_open && (r_count != '0)))
        else $error("granted challenge left no open window");

endmodule

[bench/tcp_endpoint_challenge_ack_limiter_tb.sv]
`timescale 1ns / 100ps
// Testbench for the TCP challenge-ACK limiter: drives segment requests and APB register
// writes, predicts every response with a scoreboard class and checks it field by field.
// Depends on tcal_pkg, tcal_if.sv and the top level tcp_endpoint_challenge_ack_limiter.
module tcp_endpoint_challenge_ack_limiter_tb;
    import tcal_pkg::*;

    localparam logic [2:0] EV_BAD_LO = 3'd6;
    localparam logic [2:0] EV_BAD_HI = 3'd7;
    localparam int MAX_PRINTED = 50;

    // next state and reply per [state][event], one nibble each
    localparam logic [0:9][0:5][3:0] CONN_NEXT = {
        24'h100009, 24'h123015, 24'h223925, 24'h333934, 24'h494944,
        24'h567955, 24'h668966, 24'h787977, 24'h888888, 24'h999999
    };
    localparam logic [0:9][0:5][3:0] CONN_REPLY = {
        24'h130030, 24'h002004, 24'h202024, 24'h202024, 24'h202000,
        24'h202020, 24'h202020, 24'h202000, 24'h202000, 24'h333030
    };

    typedef struct packed {
        t_code       reply;
        t_state      conn_state;
        logic        suppressed;
        logic [31:0] granted;
        logic [31:0] withheld;
    } ack_result_t;

    class ack_limit_scoreboard;
        logic [LIMIT_WIDTH-1:0] ack_limit;
        logic [31:0]            window_len;
        t_state                 conn;
        logic [31:0]            win_start;
        logic                   win_open;
        logic [LIMIT_WIDTH-1:0] chal_count;
        logic [31:0]            granted;
        logic [31:0]            withheld;
        ack_result_t            due_replies[$];
        int                     errors;

        function new();
            ack_limit  = ACK_LIMIT_RST;
            window_len = WINDOW_LEN_RST;
            conn       = ST_LISTEN;
            win_start  = '0;
            win_open   = 1'b0;
            chal_count = '0;
            granted    = '0;
            withheld   = '0;
            errors     = 0;
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTED)
                $display("%0t mismatch: %s", $time, msg);
            errors++;
        endtask

        function void note_segment(logic c, logic [2:0] ev, logic [31:0] now);
            ack_result_t r;
            logic [31:0] elapsed;
            r = '0;
            elapsed = now - win_start;
            if (c == CMD_RESET) begin
                conn       = ST_LISTEN;
                win_start  = '0;
                win_open   = 1'b0;
                chal_count = '0;
            end else if (ev < NUM_EVENTS) begin
                r.reply = CONN_REPLY[conn][ev][2:0];
                if (ev == EV_SYN && conn >= ST_CHAL_FIRST && conn <= ST_CHAL_LAST) begin
                    if (!win_open || elapsed >= window_len) begin
                        win_start  = now;
                        win_open   = 1'b1;
                        chal_count = LIMIT_WIDTH'(1);
                        if (granted != '1) granted++;
                    end else if (chal_count < ack_limit) begin
                        chal_count++;
                        if (granted != '1) granted++;
                    end else begin
                        r.reply      = RP_SILENT;
                        r.suppressed = 1'b1;
                        if (withheld != '1) withheld++;
                    end
                end
                conn = CONN_NEXT[conn][ev];
            end
            r.conn_state = conn;
            r.granted    = granted;
            r.withheld   = withheld;
            due_replies.insert(due_replies.size(), r);
        endfunction

        task check_reply(t_code reply, t_state conn_state, logic supp,
                         logic [31:0] g, logic [31:0] w);
            ack_result_t want;
            if (due_replies.size() == 0) begin
                report($sformatf("response with nothing outstanding, state %0d", conn_state));
                return;
            end
            want = due_replies.pop_front();
            if (reply !== want.reply)
                report($sformatf("reply %0d, want %0d", reply, want.reply));
            if (conn_state !== want.conn_state)
                report($sformatf("conn_state %0d, want %0d", conn_state, want.conn_state));
            if (supp !== want.suppressed)
                report($sformatf("was_suppressed %0b, want %0b", supp, want.suppressed));
            if (g !== want.granted)
                report($sformatf("granted_total %0d, want %0d", g, want.granted));
            if (w !== want.withheld)
                report($sformatf("suppressed_total %0d, want %0d", w, want.withheld));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_WIDTH-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tcal_req_if req();
    tcal_rsp_if rsp();

    ack_limit_scoreboard sb = new();

    bit          steady;
    int          stall_left;
    int          counted_items;
    logic [31:0] tick_now;

    tcp_endpoint_challenge_ack_limiter uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("FAIL tcp_endpoint_challenge_ack_limiter");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [2:0] pick_event();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return EV_SYN;
        if (r < 57) return EV_ACK;
        if (r < 67) return EV_FIN;
        if (r < 72) return EV_RST;
        if (r < 87) return EV_DATA;
        if (r < 95) return EV_CLOSE;
        return 3'($urandom_range(EV_BAD_LO, EV_BAD_HI));
    endfunction

    // advance mostly in small steps; sometimes aim at the window edge or jump anywhere
    function automatic logic [31:0] next_time();
        int r;
        logic [31:0] span;
        r = $urandom_range(0, 99);
        span = (sb.window_len > 4000) ? 32'd1000 : sb.window_len / 4 + 1;
        if (r < 12)
            tick_now = tick_now;
        else if (r < 80)
            tick_now = tick_now + $urandom_range(0, span);
        else if (r < 92)
            tick_now = sb.win_start + sb.window_len + $urandom_range(0, 2) - 1;
        else
            tick_now = $urandom;
        return tick_now;
    endfunction

    // receive side: random stalls
    initial begin
        rsp.ready <= 1'b0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left == 0) begin
                rsp.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            end else begin
                rsp.ready <= 1'b0;
                stall_left--;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp.valid && rsp.ready)
            sb.check_reply(rsp.reply, rsp.conn_state, rsp.was_suppressed,
                           rsp.granted_total, rsp.suppressed_total);
    end

    task automatic send_req(input logic c, input logic [2:0] ev, input logic [31:0] now);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.valid     <= 1'b1;
        req.cmd       <= c;
        req.event_req <= ev;
        req.time_now  <= now;
        do @(posedge i_clk); while (!req.ready);
        sb.note_segment(c, ev, now);
        if (c == CMD_RESET || ev < NUM_EVENTS) counted_items++;
    endtask

    task automatic hold_until_empty(input int settle);
        req.valid <= 1'b0;
        do @(posedge i_clk); while (sb.due_replies.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_regs();
        logic [31:0] rd;
        apb_access(1'b0, REG_ACK_LIMIT, 32'd0, rd);
        if (rd !== {11'd0, sb.ack_limit})
            sb.report($sformatf("ack_limit reads %0d, want %0d", rd, sb.ack_limit));
        apb_access(1'b0, REG_WINDOW_LEN, 32'd0, rd);
        if (rd !== sb.window_len)
            sb.report($sformatf("window_len reads %0d, want %0d", rd, sb.window_len));
    endtask

    task automatic apply_config(input logic [LIMIT_WIDTH-1:0] limit, input logic [31:0] wlen);
        logic [31:0] rd;
        hold_until_empty(4);
        apb_access(1'b1, REG_ACK_LIMIT, {11'd0, limit}, rd);
        apb_access(1'b1, REG_WINDOW_LEN, wlen, rd);
        sb.ack_limit  = limit;
        sb.window_len = wlen;
        check_regs();
    endtask

    task automatic run_directed();
        send_req(CMD_RESET, EV_BAD_HI, 32'hFFFF_FFFF);
        send_req(CMD_EVENT, EV_BAD_LO, 32'h0000_0000);
        send_req(CMD_EVENT, EV_SYN,    32'h0000_0000);
        send_req(CMD_EVENT, EV_ACK,    32'h0000_0000);
        send_req(CMD_EVENT, EV_SYN,    32'hFFFF_FFF0);
        send_req(CMD_EVENT, EV_SYN,    32'h0000_0005);
        send_req(CMD_EVENT, EV_SYN,    32'h0000_26FF);
        send_req(CMD_EVENT, EV_SYN,    32'h0000_2700);
        send_req(CMD_EVENT, EV_FIN,    32'h0000_2800);
        send_req(CMD_EVENT, EV_SYN,    32'h0000_2900);
        send_req(CMD_EVENT, EV_CLOSE,  32'h0000_2A00);
        send_req(CMD_EVENT, EV_SYN,    32'h0000_2B00);
        send_req(CMD_EVENT, EV_ACK,    32'h0000_2C00);
        send_req(CMD_EVENT, EV_SYN,    32'h0000_2D00);
        send_req(CMD_EVENT, EV_BAD_HI, 32'h8000_0000);
        send_req(CMD_RESET, EV_SYN,    32'h5555_5555);
        send_req(CMD_EVENT, EV_CLOSE,  32'h0000_3000);
        send_req(CMD_RESET, EV_DATA,   32'hAAAA_AAAA);
        send_req(CMD_EVENT, EV_SYN,    32'h0000_3100);
        send_req(CMD_EVENT, EV_ACK,    32'h0000_3200);
        send_req(CMD_EVENT, EV_CLOSE,  32'h0000_3300);
        send_req(CMD_EVENT, EV_ACK,    32'h0000_3400);
        send_req(CMD_EVENT, EV_FIN,    32'h0000_3500);
        send_req(CMD_EVENT, EV_SYN,    32'h0000_3600);
        send_req(CMD_EVENT, EV_DATA,   32'h0000_3700);
    endtask

    // mostly well-formed connections with random events; some noise bursts
    task automatic run_random(input int quota);
        int stop_at;
        int r;
        int n;
        stop_at = counted_items + quota;
        while (counted_items < stop_at) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 8) steady = !steady;
            if ($urandom_range(0, 99) < 2) hold_until_empty(1);
            if (r < 15) begin
                n = $urandom_range(1, 8);
                repeat (n) begin
                    send_req(($urandom_range(0, 4) != 0) ? CMD_EVENT : CMD_RESET,
                             3'($urandom_range(0, 7)), $urandom);
                end
            end else begin
                if ($urandom_range(0, 9) != 0)
                    send_req(CMD_RESET, 3'($urandom_range(0, 7)), $urandom);
                if ($urandom_range(0, 9) != 0)
                    send_req(CMD_EVENT, EV_SYN, next_time());
                if ($urandom_range(0, 19) > 2)
                    send_req(CMD_EVENT, EV_ACK, next_time());
                n = $urandom_range(4, 40);
                repeat (n) send_req(CMD_EVENT, pick_event(), next_time());
            end
        end
    endtask

    initial begin
        int waited;
        req.valid     <= 1'b0;
        req.cmd       <= CMD_EVENT;
        req.event_req <= EV_SYN;
        req.time_now  <= 32'd0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= 32'd0;
        i_rst_n       <= 1'b0;
        steady        = 1'b0;
        counted_items = 0;
        tick_now      = $urandom;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        check_regs();
        run_directed();

        run_random(250);
        steady = 1'b1;
        apply_config(21'd0, 32'd0);
        run_random(120);
        steady = 1'b0;
        apply_config(21'd0, 32'd60);
        run_random(150);
        apply_config(21'd2, 32'd30);
        run_random(200);
        steady = 1'b1;
        apply_config(21'd1048576, 32'hFFFF_FFFF);
        run_random(130);
        steady = 1'b0;
        apply_config(21'd1, 32'd1);
        run_random(100);
        apply_config(21'd1048575, 32'd50);
        run_random(200);

        req.valid <= 1'b0;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (sb.due_replies.size() != 0 && waited < 20000);
        repeat (8) @(posedge i_clk);
        if (sb.due_replies.size() != 0)
            sb.report($sformatf("%0d responses never arrived", sb.due_replies.size()));
        if (sb.errors == 0)
            $display("PASS tcp_endpoint_challenge_ack_limiter");
        else
            $display("FAIL tcp_endpoint_challenge_ack_limiter");
        $finish;
    end

endmodule
